// ----- sv/obdt_pkg.sv -----
// ---------------------------------------------------------------------------
// obdt_pkg
// Shared types and constants of the order book depth tracker.
// ---------------------------------------------------------------------------
package obdt_pkg;

  localparam int PriceW = 31;
  localparam int QtyW   = 32;
  localparam int DepthW = 4;
  localparam int RowW   = 5;

  localparam logic CMD_SNAP  = 1'b0;
  localparam logic CMD_TRADE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_LOWER,
    ST_DUMP
  } obdt_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic stage_wr;   // store snapshot level in the staging book
    logic commit;     // compute changes and copy staging into the book
    logic trade_pre;  // clear changes, set best prices before any snapshot
    logic align;      // shift both sides toward the tick's best prices
    logic lower;      // lower quantities at the traded price
    logic dump_start; // reset the row counter
    logic dump_step;  // present one row and advance
  } obdt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic seen;       // a snapshot has been committed
    logic dump_last;  // the row counter is on the final row
  } obdt_stat_t;

endpackage

// ----- sv/obdt_ctrl.sv -----
// ---------------------------------------------------------------------------
// obdt_ctrl
// Sequencer: decodes an item and steps the datapath through its phases.
// ---------------------------------------------------------------------------
module obdt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  input  logic                in_last_level,
  input  obdt_pkg::obdt_stat_t stat,
  output logic                busy,
  output obdt_pkg::obdt_cmd_t cmd
);
  import obdt_pkg::*;

  obdt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_SNAP) begin
            cmd.stage_wr = 1'b1;
            if (in_last_level) begin
              cmd.commit     = 1'b1;
              cmd.dump_start = 1'b1;
              state_nxt      = ST_DUMP;
            end
          end else begin
            cmd.trade_pre  = 1'b1;
            cmd.dump_start = 1'b1;
            state_nxt      = stat.seen ? ST_ALIGN : ST_DUMP;
          end
        end
      end
      ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = ST_LOWER;
      end
      ST_LOWER: begin
        cmd.lower = 1'b1;
        state_nxt = ST_DUMP;
      end
      ST_DUMP: begin
        cmd.dump_step = 1'b1;
        if (stat.dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/obdt_dp.sv -----
// ---------------------------------------------------------------------------
// obdt_dp
// Book storage, staging book, commit, alignment, trade lowering and row dump.
// ---------------------------------------------------------------------------
module obdt_dp #(
  parameter int LEVELS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  obdt_pkg::obdt_cmd_t        cmd,
  output obdt_pkg::obdt_stat_t       stat,
  input  logic                       in_side,
  input  logic [obdt_pkg::DepthW-1:0] in_depth,
  input  logic [obdt_pkg::PriceW-1:0] in_level_price,
  input  logic [obdt_pkg::QtyW-1:0]   in_level_quantity,
  input  logic [obdt_pkg::PriceW-1:0] in_trade_price,
  input  logic [obdt_pkg::QtyW-1:0]   in_trade_volume,
  input  logic                       in_aggressor_buy,
  input  logic [obdt_pkg::PriceW-1:0] in_best_ask,
  input  logic [obdt_pkg::PriceW-1:0] in_best_bid,
  output logic                       out_valid,
  output logic [obdt_pkg::RowW-1:0]   out_row,
  output logic [obdt_pkg::PriceW-1:0] out_price,
  output logic [obdt_pkg::QtyW-1:0]   out_remaining,
  output logic signed [obdt_pkg::QtyW-1:0] out_change,
  output logic                       out_last_row
);
  import obdt_pkg::*;

  localparam int Rows = 2 * LEVELS;
  localparam int IdxW = $clog2(Rows);
  localparam int LvW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [PriceW-1:0] bp_r [Rows];
  logic [QtyW-1:0]   bq_r [Rows];
  logic [QtyW-1:0]   bc_r [Rows];
  logic [PriceW-1:0] sp_r [Rows];
  logic [QtyW-1:0]   sq_r [Rows];
  logic              seen_r;
  logic [IdxW-1:0]   cnt_r;
  logic              ov_r, olast_r;
  logic [IdxW-1:0]   orow_r;
  logic [PriceW-1:0] op_r;
  logic [QtyW-1:0]   oq_r, oc_r;

  // trade parameters latched at accept
  logic [PriceW-1:0] tp_r, ask_r, bid_r;
  logic [QtyW-1:0]   vol_r;
  logic              buy_r;

  // staging book with the level of the current item merged in
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [PriceW-1:0] spe [Rows];
  logic [QtyW-1:0]   sqe [Rows];
  always_comb begin
    wr_en  = cmd.stage_wr && (int'(in_depth) < LEVELS);
    wr_idx = in_side ? IdxW'(LEVELS + int'(in_depth)) : IdxW'(LEVELS - 1 - int'(in_depth));
    for (int i = 0; i < Rows; i++) begin
      spe[i] = sp_r[i];
      sqe[i] = sq_r[i];
      if (wr_en && (wr_idx == IdxW'(i))) begin
        spe[i] = in_level_price;
        sqe[i] = in_level_quantity;
      end
    end
  end

  // per-row change against the old book, same side, first match
  logic [QtyW-1:0] chg [Rows];
  always_comb begin
    for (int i = 0; i < Rows; i++) begin
      logic hit;
      hit    = 1'b0;
      chg[i] = '0;
      for (int j = 0; j < LEVELS; j++) begin
        if (!hit && bp_r[((i < LEVELS) ? 0 : LEVELS) + j] == spe[i]) begin
          hit    = 1'b1;
          chg[i] = sqe[i] - bq_r[((i < LEVELS) ? 0 : LEVELS) + j];
        end
      end
      if (!seen_r) begin
        chg[i] = '0;
      end
    end
  end

  // alignment: find best prices and the required shift per side
  logic          a_fnd, b_fnd, a_ok, b_ok;
  logic [LvW-1:0] a_pos, b_pos;
  always_comb begin
    a_fnd = 1'b0;
    b_fnd = 1'b0;
    a_pos = '0;
    b_pos = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!a_fnd && bp_r[i] == ask_r) begin
        a_fnd = 1'b1;
        a_pos = LvW'(i);
      end
      if (!b_fnd && bp_r[LEVELS + i] == bid_r) begin
        b_fnd = 1'b1;
        b_pos = LvW'(i);
      end
    end
    a_ok = (bp_r[LEVELS-1] == ask_r);
    b_ok = (bp_r[LEVELS] == bid_r);
  end

  // shifted sides
  logic [PriceW-1:0] np [Rows];
  logic [QtyW-1:0]   nq [Rows];
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      // ask side: entry k takes src = k - n
      np[k] = bp_r[k];
      nq[k] = bq_r[k];
      if (!a_ok) begin
        if (!a_fnd) begin
          if (k == LEVELS - 1) begin
            np[k] = ask_r;
            nq[k] = '0;
          end else begin
            np[k] = bp_r[k + 1];
            nq[k] = bq_r[k + 1];
          end
        end else if (k >= LEVELS - 1 - int'(a_pos)) begin
          np[k] = bp_r[k - (LEVELS - 1 - int'(a_pos))];
          nq[k] = bq_r[k - (LEVELS - 1 - int'(a_pos))];
        end else begin
          np[k] = '0;
          nq[k] = '0;
        end
      end
      // bid side: shift toward lower index by b_pos
      np[LEVELS + k] = bp_r[LEVELS + k];
      nq[LEVELS + k] = bq_r[LEVELS + k];
      if (!b_ok) begin
        if (!b_fnd) begin
          if (k == 0) begin
            np[LEVELS + k] = bid_r;
            nq[LEVELS + k] = '0;
          end else begin
            np[LEVELS + k] = bp_r[LEVELS + k - 1];
            nq[LEVELS + k] = bq_r[LEVELS + k - 1];
          end
        end else if (k + int'(b_pos) < LEVELS) begin
          np[LEVELS + k] = bp_r[LEVELS + k + int'(b_pos)];
          nq[LEVELS + k] = bq_r[LEVELS + k + int'(b_pos)];
        end else begin
          np[LEVELS + k] = '0;
          nq[LEVELS + k] = '0;
        end
      end
    end
  end

  // book, staging and change storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Rows; i++) begin
        bp_r[i] <= '0;
        bq_r[i] <= '0;
        bc_r[i] <= '0;
        sp_r[i] <= '0;
        sq_r[i] <= '0;
      end
      seen_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        for (int i = 0; i < Rows; i++) begin
          bc_r[i] <= chg[i];
          bp_r[i] <= spe[i];
          bq_r[i] <= sqe[i];
          sp_r[i] <= '0;
          sq_r[i] <= '0;
        end
        seen_r <= 1'b1;
      end else if (wr_en) begin
        sp_r[wr_idx] <= in_level_price;
        sq_r[wr_idx] <= in_level_quantity;
      end
      if (cmd.trade_pre) begin
        for (int i = 0; i < Rows; i++) begin
          bc_r[i] <= '0;
        end
        if (!seen_r) begin
          bp_r[LEVELS-1] <= in_best_ask;
          bp_r[LEVELS]   <= in_best_bid;
        end
      end
      if (cmd.align) begin
        for (int i = 0; i < Rows; i++) begin
          bp_r[i] <= np[i];
          bq_r[i] <= nq[i];
        end
      end
      if (cmd.lower) begin
        for (int i = 0; i < Rows; i++) begin
          if (((i < LEVELS) == buy_r) && bp_r[i] == tp_r) begin
            bq_r[i] <= (vol_r >= bq_r[i]) ? '0 : bq_r[i] - vol_r;
          end
        end
      end
    end
  end

  // trade parameter capture
  always_ff @(posedge clk) begin
    if (cmd.trade_pre) begin
      tp_r  <= in_trade_price;
      vol_r <= in_trade_volume;
      buy_r <= in_aggressor_buy;
      ask_r <= in_best_ask;
      bid_r <= in_best_bid;
    end
  end

  // row counter and registered output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      ov_r    <= cmd.dump_step;
      olast_r <= cmd.dump_step && stat.dump_last;
      if (cmd.dump_start) begin
        cnt_r <= '0;
      end else if (cmd.dump_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_step) begin
      orow_r <= cnt_r;
      op_r   <= bp_r[cnt_r];
      oq_r   <= bq_r[cnt_r];
      oc_r   <= bc_r[cnt_r];
    end
  end

  assign stat.seen      = seen_r;
  assign stat.dump_last = (cnt_r == IdxW'(Rows - 1));
  assign out_valid      = ov_r;
  assign out_row        = RowW'(orow_r);
  assign out_price      = op_r;
  assign out_remaining  = oq_r;
  assign out_change     = oc_r;
  assign out_last_row   = olast_r;

endmodule

// ----- sv/order_book_depth_tracker.sv -----
// ---------------------------------------------------------------------------
// order_book_depth_tracker
// Two-sided limit order book of 2*LEVELS levels with per-level changes.
// ---------------------------------------------------------------------------
// A snapshot level item leaves busy low. The item that closes a snapshot and
// every trade tick dump the whole book, one row per cycle on out_valid, and
// keep busy high for the dump (a trade after a snapshot first passes through
// the alignment shift and the quantity update). Rows come out in order, row
// 0 first, from a register behind the dump step, so the final row shows in
// the cycle after busy falls; out_last_row marks it. The receiver must take
// each row in the cycle it is shown.
module order_book_depth_tracker #(
  parameter int LEVELS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic                        in_side,
  input  logic [obdt_pkg::DepthW-1:0] in_depth,
  input  logic [obdt_pkg::PriceW-1:0] in_level_price,
  input  logic [obdt_pkg::QtyW-1:0]   in_level_quantity,
  input  logic                        in_last_level,
  input  logic [obdt_pkg::PriceW-1:0] in_trade_price,
  input  logic [obdt_pkg::QtyW-1:0]   in_trade_volume,
  input  logic                        in_aggressor_buy,
  input  logic [obdt_pkg::PriceW-1:0] in_best_ask,
  input  logic [obdt_pkg::PriceW-1:0] in_best_bid,
  output logic                        out_valid,
  output logic [obdt_pkg::RowW-1:0]   out_row,
  output logic [obdt_pkg::PriceW-1:0] out_price,
  output logic [obdt_pkg::QtyW-1:0]   out_remaining,
  output logic signed [obdt_pkg::QtyW-1:0] out_change,
  output logic                        out_last_row
);
  import obdt_pkg::*;

  obdt_cmd_t  cmd;
  obdt_stat_t stat;

  // sequencer
  obdt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_cmd       (in_cmd),
    .in_last_level(in_last_level),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  // book datapath
  obdt_dp #(.LEVELS(LEVELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_side          (in_side),
    .in_depth         (in_depth),
    .in_level_price   (in_level_price),
    .in_level_quantity(in_level_quantity),
    .in_trade_price   (in_trade_price),
    .in_trade_volume  (in_trade_volume),
    .in_aggressor_buy (in_aggressor_buy),
    .in_best_ask      (in_best_ask),
    .in_best_bid      (in_best_bid),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_price        (out_price),
    .out_remaining    (out_remaining),
    .out_change       (out_change),
    .out_last_row     (out_last_row)
  );

endmodule

// ----- sv/obdt_checker.sv -----
// ---------------------------------------------------------------------------
// obdt_checker
// Port-level checks of the row dump sequence.
// ---------------------------------------------------------------------------
module obdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input logic [obdt_pkg::RowW-1:0]   out_row,
  input logic                        out_last_row
);
  import obdt_pkg::*;

  // rows only appear right after busy was high
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("row outside busy");

  // last row only on a valid row
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_row |-> out_valid) else $error("last row without row");

  // consecutive rows count up
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |=> out_valid && out_row == $past(out_row) + 1'b1)
    else $error("row sequence broken");

  // a dump starts at row zero
  a_row_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_row == '0) else $error("dump not from row zero");

endmodule

bind order_book_depth_tracker obdt_checker u_obdt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_row     (out_row),
  .out_last_row(out_last_row)
);

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives snapshot levels and trade ticks into the order book depth tracker,
// predicts every dumped row from its own copy of the book and checks the rows
// field by field as they come out.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import obdt_pkg::*;

  localparam int Levels = 10;
  localparam int Rows   = 2 * Levels;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   remaining;
    logic [QtyW-1:0]   change;
    logic              last_row;
  } book_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_SNAP;
  logic in_side = 1'b0;
  logic [DepthW-1:0] in_depth = '0;
  logic [PriceW-1:0] in_level_price = '0;
  logic [QtyW-1:0] in_level_quantity = '0;
  logic in_last_level = 1'b0;
  logic [PriceW-1:0] in_trade_price = '0;
  logic [QtyW-1:0] in_trade_volume = '0;
  logic in_aggressor_buy = 1'b0;
  logic [PriceW-1:0] in_best_ask = '0;
  logic [PriceW-1:0] in_best_bid = '0;
  logic out_valid;
  logic [RowW-1:0] out_row;
  logic [PriceW-1:0] out_price;
  logic [QtyW-1:0] out_remaining;
  logic signed [QtyW-1:0] out_change;
  logic out_last_row;

  // predicted book
  logic [PriceW-1:0] bk_price [Rows];
  logic [QtyW-1:0]   bk_qty   [Rows];
  logic [QtyW-1:0]   bk_chg   [Rows];
  logic [PriceW-1:0] stg_price [Rows];
  logic [QtyW-1:0]   stg_qty   [Rows];
  logic              seen;

  book_row_t expected_rows [$];
  int errors = 0;
  int send_idle_pct = 0;

  always #2 clk = ~clk;

  order_book_depth_tracker #(.LEVELS(Levels)) dut (.*);

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // shift one side by n places toward higher rows
  function automatic void shift_side(input int base, input int n);
    logic [PriceW-1:0] p [Levels];
    logic [QtyW-1:0] q [Levels];
    for (int k = 0; k < Levels; k++) begin
      p[k] = bk_price[base + k];
      q[k] = bk_qty[base + k];
    end
    for (int k = 0; k < Levels; k++) begin
      if (k - n >= 0 && k - n < Levels) begin
        bk_price[base + k] = p[k - n];
        bk_qty[base + k] = q[k - n];
      end else begin
        bk_price[base + k] = '0;
        bk_qty[base + k] = '0;
      end
    end
  endfunction

  function automatic void book_dump();
    book_row_t r;
    for (int i = 0; i < Rows; i++) begin
      r.row = RowW'(i);
      r.price = bk_price[i];
      r.remaining = bk_qty[i];
      r.change = bk_chg[i];
      r.last_row = (i == Rows - 1);
      expected_rows.push_back(r);
    end
  endfunction

  function automatic void book_snapshot(input logic side, input logic [DepthW-1:0] depth,
                                        input logic [PriceW-1:0] p, input logic [QtyW-1:0] q,
                                        input logic last);
    int idx;
    int found;
    if (depth < Levels) begin
      idx = side ? Levels + int'(depth) : Levels - 1 - int'(depth);
      stg_price[idx] = p;
      stg_qty[idx] = q;
    end
    if (!last) return;
    // changes against the first equal price on the same side
    for (int i = 0; i < Rows; i++) begin
      bk_chg[i] = '0;
      if (seen) begin
        found = 0;
        for (int j = (i < Levels ? 0 : Levels); j < (i < Levels ? Levels : Rows); j++)
          if (!found && bk_price[j] == stg_price[i]) begin
            bk_chg[i] = stg_qty[i] - bk_qty[j];
            found = 1;
          end
      end
    end
    for (int i = 0; i < Rows; i++) begin
      bk_price[i] = stg_price[i];
      bk_qty[i] = stg_qty[i];
      stg_price[i] = '0;
      stg_qty[i] = '0;
    end
    seen = 1'b1;
    book_dump();
  endfunction

  function automatic void book_trade(input logic [PriceW-1:0] tp, input logic [QtyW-1:0] vol,
                                     input logic buy, input logic [PriceW-1:0] ask,
                                     input logic [PriceW-1:0] bid);
    int found;
    int base;
    for (int i = 0; i < Rows; i++) bk_chg[i] = '0;
    if (!seen) begin
      bk_price[Levels - 1] = ask;
      bk_price[Levels] = bid;
    end else begin
      if (bk_price[Levels - 1] != ask) begin
        found = -1;
        for (int i = Levels - 1; i >= 0; i--) if (bk_price[i] == ask) found = i;
        if (found < 0) begin
          shift_side(0, -1);
          bk_price[Levels - 1] = ask;
        end else shift_side(0, Levels - 1 - found);
      end
      if (bk_price[Levels] != bid) begin
        found = -1;
        for (int i = Rows - 1; i >= Levels; i--) if (bk_price[i] == bid) found = i;
        if (found < 0) begin
          shift_side(Levels, 1);
          bk_price[Levels] = bid;
        end else shift_side(Levels, Levels - found);
      end
      base = buy ? 0 : Levels;
      for (int i = base; i < base + Levels; i++)
        if (bk_price[i] == tp) bk_qty[i] = (vol >= bk_qty[i]) ? '0 : bk_qty[i] - vol;
    end
    book_dump();
  endfunction

  // one transfer on the command port, all fields driven
  task automatic send_item(input logic cmd, input logic side, input logic [DepthW-1:0] depth,
                           input logic [PriceW-1:0] lp, input logic [QtyW-1:0] lq,
                           input logic last, input logic [PriceW-1:0] tp,
                           input logic [QtyW-1:0] tv, input logic buy,
                           input logic [PriceW-1:0] ask, input logic [PriceW-1:0] bid);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_cmd <= cmd; in_side <= side; in_depth <= depth;
    in_level_price <= lp; in_level_quantity <= lq; in_last_level <= last;
    in_trade_price <= tp; in_trade_volume <= tv; in_aggressor_buy <= buy;
    in_best_ask <= ask; in_best_bid <= bid;
    start <= 1'b1;
    // busy is stable between edges; the transfer happens at the next rising edge
    while (busy) @(negedge clk);
    @(posedge clk);
    if (cmd == CMD_SNAP) book_snapshot(side, depth, lp, lq, last);
    else book_trade(tp, tv, buy, ask, bid);
    @(negedge clk);
  endtask

  task automatic snap(input logic side, input int depth, input logic [PriceW-1:0] p,
                      input logic [QtyW-1:0] q, input logic last);
    send_item(CMD_SNAP, side, DepthW'(depth), p, q, last, PriceW'($urandom),
              $urandom, 1'($urandom), PriceW'($urandom), PriceW'($urandom));
  endtask

  task automatic trade(input logic [PriceW-1:0] tp, input logic [QtyW-1:0] v, input logic buy,
                       input logic [PriceW-1:0] ask, input logic [PriceW-1:0] bid);
    send_item(CMD_TRADE, 1'($urandom), DepthW'($urandom), PriceW'($urandom), $urandom,
              1'($urandom), tp, v, buy, ask, bid);
  endtask

  // compare each row with the oldest expectation
  always @(posedge clk) begin
    book_row_t e;
    if (rst_n && out_valid) begin
      if (expected_rows.size() == 0) report("row with no expectation");
      else begin
        e = expected_rows.pop_front();
        if (out_row !== e.row) report($sformatf("row %0d exp %0d", out_row, e.row));
        if (out_price !== e.price)
          report($sformatf("row %0d price %0d exp %0d", e.row, out_price, e.price));
        if (out_remaining !== e.remaining)
          report($sformatf("row %0d remaining %0d exp %0d", e.row, out_remaining, e.remaining));
        if (out_change !== e.change)
          report($sformatf("row %0d change %0d exp %0d", e.row, out_change, e.change));
        if (out_last_row !== e.last_row)
          report($sformatf("row %0d last_row %b exp %b", e.row, out_last_row, e.last_row));
      end
    end
  end

  task automatic test_trade_before_snapshot();
    trade(31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 31'h7FFFFFFF, 31'd0);
    trade(31'd0, 32'd0, 1'b0, 31'd100, 31'd99);
  endtask

  task automatic test_directed_snapshots();
    // full book, extremes in fields, out of range depth carrying the commit
    for (int d = 0; d < Levels; d++) begin
      snap(1'b0, d, 31'(100 + d), 32'(10 * (d + 1)), 1'b0);
      snap(1'b1, d, 31'(99 - d), 32'(10 * (d + 1)), 1'b0);
    end
    snap(1'b0, 15, 31'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
    // second snapshot: changes incl. wrapping and empty levels at price zero
    snap(1'b0, 0, 31'd100, 32'd0, 1'b0);
    snap(1'b1, 0, 31'd99, 32'hFFFFFFFF, 1'b0);
    snap(1'b1, 9, 31'h7FFFFFFF, 32'd5, 1'b1);
    // absent best price on both sides, then present deeper
    trade(31'd0, 32'd3, 1'b1, 31'd150, 31'd50);
    snap(1'b0, 0, 31'd200, 32'd40, 1'b0);
    snap(1'b0, 3, 31'd200, 32'd7, 1'b0);
    snap(1'b1, 0, 31'd190, 32'd40, 1'b0);
    snap(1'b1, 2, 31'd180, 32'd40, 1'b1);
    trade(31'd200, 32'd5, 1'b1, 31'd200, 31'd180);
    trade(31'd180, 32'hFFFFFFFF, 1'b0, 31'd200, 31'd180);
  endtask

  task automatic test_random(input int n);
    int base;
    int lv;
    for (int k = 0; k < n; k++) begin
      base = $urandom_range(1000, 1020);
      if ($urandom_range(99) < 35) begin
        trade(31'(base + $urandom_range(0, 12) - 6),
              ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(0, 60)),
              1'($urandom), 31'(base + $urandom_range(0, 3)),
              31'(base - $urandom_range(1, 4)));
      end else if ($urandom_range(99) < 10) begin
        // noise: wide random fields
        snap(1'($urandom), $urandom_range(15), PriceW'($urandom), $urandom,
             1'($urandom_range(3) == 0));
      end else begin
        lv = $urandom_range(1, 6);
        for (int j = 0; j < lv; j++) begin
          snap(1'($urandom), $urandom_range(0, ($urandom_range(9) == 0) ? 15 : 9),
               31'(base + $urandom_range(0, 10) - 5), 32'($urandom_range(0, 100)),
               j == lv - 1);
          k++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Rows; i++) begin
      bk_price[i] = '0; bk_qty[i] = '0; bk_chg[i] = '0;
      stg_price[i] = '0; stg_qty[i] = '0;
    end
    seen = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_trade_before_snapshot();
    test_directed_snapshots();
    send_idle_pct = 17;
    test_random(70);
    send_idle_pct = 48;
    test_random(70);
    send_idle_pct = 0;
    test_random(70);
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
